// ===== hw/rtl/ngm_pkg.sv =====
// ----------------------------------------------------------------------------
// Node guarding master package
// Item types, command codes and fixed constants shared by the monitor.
// ----------------------------------------------------------------------------
package ngm_pkg;

	localparam logic [1:0] MODE_TICK  = 2'd0;
	localparam logic [1:0] MODE_FRAME = 2'd1;
	localparam logic [1:0] MODE_SETUP = 2'd2;

	localparam int MAX_RESULTS = 8;
	localparam int RCNT_W      = $clog2(MAX_RESULTS + 1);
	localparam int RIDX_W      = $clog2(MAX_RESULTS);

	localparam logic [6:0]  STATE_OPERATIONAL = 7'd5;
	localparam logic [3:0]  GUARD_BASE_HI     = 4'hE;   // identifier bits 10..7 of 0x700
	localparam logic [7:0]  TOGGLE_MASK       = 8'h80;
	localparam logic [7:0]  STATE_MASK        = 8'h7F;

	typedef struct packed {
		logic [1:0]  mode;
		logic [15:0] elapsed_ms;
		logic        tx_busy;
		logic [10:0] frame_id;
		logic [3:0]  frame_len;
		logic [7:0]  frame_byte;
		logic [2:0]  slot;
		logic [6:0]  node_id;
		logic [15:0] guard_time_ms;
	} in_item_t;

	typedef struct packed {
		logic [6:0] slot_node_id;
		logic       send_request;
		logic       report_error;
		logic       clear_error;
		logic       all_active;
		logic       all_operational;
		logic       status;
		logic       last;
	} out_item_t;

	// Handshake between the front queue and the back sequencer.
	typedef struct packed {
		logic     valid;
		in_item_t cmd;
	} cmd_req_t;

endpackage

// ===== hw/rtl/ngm_chan_if.sv =====
// ----------------------------------------------------------------------------
// Node guarding master channel
// Valid/ready channel carrying one item of a given payload type.
// ----------------------------------------------------------------------------
interface ngm_chan_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/ngm_front.sv =====
// ----------------------------------------------------------------------------
// Node guarding master front end
// Accepts items, drops those that cannot have any effect, queues the rest.
// ----------------------------------------------------------------------------
module ngm_front (
	input  logic             clk,
	input  logic             arst_n,
	ngm_chan_if.sink         req,
	output ngm_pkg::cmd_req_t cmd,
	input  logic             cmd_ready
);
	import ngm_pkg::*;

	in_item_t   fifo_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] cnt_q;
	logic       keep, push, pop;

	// Unused mode and frames that are not a one-byte guard reply go nowhere.
	always_comb begin
		case (req.data.mode)
			MODE_TICK, MODE_SETUP: keep = 1'b1;
			MODE_FRAME: keep = (req.data.frame_len == 4'd1) &&
				(req.data.frame_id[10:7] == GUARD_BASE_HI) &&
				(req.data.frame_id[6:0] != 7'd0);
			default: keep = 1'b0;
		endcase
	end

	assign req.ready = (cnt_q != 2'd2);
	assign push      = req.valid && req.ready && keep;
	assign pop       = cmd.valid && cmd_ready;
	assign cmd.valid = (cnt_q != 2'd0);
	assign cmd.cmd   = fifo_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop)  rptr_q <= ~rptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) fifo_q[wptr_q] <= req.data;
	end

endmodule

// ===== hw/rtl/ngm_back.sv =====
// ----------------------------------------------------------------------------
// Node guarding master back end
// Holds the slot table, walks it one slot a cycle and emits the results.
// ----------------------------------------------------------------------------
module ngm_back #(
	parameter int NODES = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ngm_pkg::cmd_req_t cmd,
	output logic              cmd_ready,
	ngm_chan_if.source        rsp
);
	import ngm_pkg::*;

	localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(NODES - 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_TICK  = 2'd1;
	localparam logic [1:0] ST_FRAME = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	typedef struct packed {
		logic [6:0] node;
		logic       snd;
		logic       rep;
		logic       clr;
		logic       status;
	} res_t;

	logic [6:0]  node_q   [NODES];
	logic [15:0] period_q [NODES];
	logic [15:0] cd_q     [NODES];
	logic [6:0]  st_q     [NODES];
	logic        known_q  [NODES];
	logic        tog_q    [NODES];
	logic        ans_q    [NODES];
	logic        busy_q   [NODES];
	logic        act_q    [NODES];

	logic [1:0]        state_q;
	in_item_t          cur_q;
	logic [IW-1:0]     idx_q;
	logic [RCNT_W-1:0] rcnt_q;
	logic [RIDX_W-1:0] eidx_q;
	logic              aa_q, ao_q, tick_q;
	res_t              res_q [MAX_RESULTS];
	logic              ov_q;
	out_item_t         od_q;

	// Per-slot tick evaluation at the walk index.
	logic        en, expired, rep, clr, act_n, snd;
	logic [15:0] cd_n;
	logic        ans_n, busy_n, aa_n, ao_n, at_end, setup_bad;
	logic        match, tog_ok, load;

	always_comb begin
		en      = (period_q[idx_q] != 16'd0) && (node_q[idx_q] != 7'd0);
		expired = !(cur_q.elapsed_ms < cd_q[idx_q]);
		rep     = 1'b0;
		clr     = 1'b0;
		act_n   = act_q[idx_q];
		if (!busy_q[idx_q]) begin
			if (!ans_q[idx_q]) begin
				act_n = 1'b0;
				rep   = 1'b1;
			end else if (known_q[idx_q]) begin
				act_n = 1'b1;
				clr   = 1'b1;
			end
		end
		snd    = !cur_q.tx_busy;
		busy_n = cur_q.tx_busy;
		ans_n  = cur_q.tx_busy ? ans_q[idx_q] : 1'b0;
		cd_n   = cur_q.tx_busy ? 16'd0 : period_q[idx_q];
		if (!expired) begin
			act_n  = act_q[idx_q];
			busy_n = busy_q[idx_q];
			ans_n  = ans_q[idx_q];
			cd_n   = cd_q[idx_q] - cur_q.elapsed_ms;
		end
		aa_n = aa_q;
		ao_n = ao_q;
		if (en && aa_q) begin
			if (act_n) begin
				if (!known_q[idx_q] || st_q[idx_q] != STATE_OPERATIONAL) ao_n = 1'b0;
			end else begin
				aa_n = 1'b0;
				ao_n = 1'b0;
			end
		end
	end

	assign at_end    = (idx_q == LAST_IDX);
	assign match     = (node_q[idx_q] == cur_q.frame_id[6:0]);
	assign tog_ok    = (((cur_q.frame_byte & TOGGLE_MASK) != 8'd0) == tog_q[idx_q]);
	assign setup_bad = (32'(cmd.cmd.slot) >= NODES) || (cmd.cmd.node_id == 7'd0);
	assign cmd_ready = (state_q == ST_IDLE);
	assign load      = (state_q == ST_EMIT) && (!ov_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			rcnt_q  <= '0;
			eidx_q  <= '0;
			ov_q    <= 1'b0;
			for (int i = 0; i < NODES; i++) begin
				node_q[i]   <= '0;
				period_q[i] <= '0;
				cd_q[i]     <= '0;
				st_q[i]     <= '0;
				known_q[i]  <= 1'b0;
				tog_q[i]    <= 1'b0;
				ans_q[i]    <= 1'b0;
				busy_q[i]   <= 1'b0;
				act_q[i]    <= 1'b0;
			end
		end else begin
			if (rsp.ready) ov_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					idx_q  <= '0;
					eidx_q <= '0;
					if (cmd.valid) begin
						case (cmd.cmd.mode)
							MODE_TICK: begin
								rcnt_q  <= '0;
								state_q <= ST_TICK;
							end
							MODE_FRAME: state_q <= ST_FRAME;
							default: begin
								rcnt_q  <= RCNT_W'(1);
								state_q <= ST_EMIT;
								if (!setup_bad) begin
									node_q[IW'(cmd.cmd.slot)]   <= cmd.cmd.node_id;
									period_q[IW'(cmd.cmd.slot)] <= cmd.cmd.guard_time_ms;
									cd_q[IW'(cmd.cmd.slot)]     <= '0;
									st_q[IW'(cmd.cmd.slot)]     <= '0;
									known_q[IW'(cmd.cmd.slot)]  <= 1'b0;
									tog_q[IW'(cmd.cmd.slot)]    <= 1'b0;
									ans_q[IW'(cmd.cmd.slot)]    <= 1'b1;
									busy_q[IW'(cmd.cmd.slot)]   <= 1'b0;
									act_q[IW'(cmd.cmd.slot)]    <= 1'b0;
								end
							end
						endcase
					end
				end
				ST_TICK: begin
					idx_q <= idx_q + IW'(1);
					if (en) begin
						cd_q[idx_q]   <= cd_n;
						act_q[idx_q]  <= act_n;
						busy_q[idx_q] <= busy_n;
						ans_q[idx_q]  <= ans_n;
						if (expired && rcnt_q != RCNT_W'(MAX_RESULTS))
							rcnt_q <= rcnt_q + RCNT_W'(1);
					end
					if (at_end) begin
						state_q <= ST_EMIT;
						if (rcnt_q == '0 && !(en && expired)) rcnt_q <= RCNT_W'(1);
					end
				end
				ST_FRAME: begin
					idx_q <= idx_q + IW'(1);
					if (match) begin
						state_q <= ST_IDLE;
						if (tog_ok) begin
							ans_q[idx_q]   <= 1'b1;
							st_q[idx_q]    <= 7'(cur_q.frame_byte & STATE_MASK);
							known_q[idx_q] <= 1'b1;
							tog_q[idx_q]   <= ~tog_q[idx_q];
						end
					end else if (at_end) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					if (load) begin
						ov_q   <= 1'b1;
						eidx_q <= eidx_q + RIDX_W'(1);
						if (RCNT_W'(eidx_q) + RCNT_W'(1) == rcnt_q) state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	// Payload registers: command, summaries, result buffer, output stage.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd.valid) begin
			cur_q  <= cmd.cmd;
			tick_q <= (cmd.cmd.mode == MODE_TICK);
			aa_q   <= 1'b1;
			ao_q   <= 1'b1;
			res_q[0] <= '{node: cmd.cmd.node_id, snd: 1'b0, rep: 1'b0, clr: 1'b0,
				status: setup_bad};
		end
		if (state_q == ST_TICK) begin
			aa_q <= aa_n;
			ao_q <= ao_n;
			if (en && expired && rcnt_q != RCNT_W'(MAX_RESULTS))
				res_q[RIDX_W'(rcnt_q)] <= '{node: node_q[idx_q], snd: snd, rep: rep,
					clr: clr, status: 1'b0};
			else if (at_end && rcnt_q == '0)
				res_q[0] <= '0;
		end
		if (load) begin
			od_q.slot_node_id    <= res_q[eidx_q].node;
			od_q.send_request    <= res_q[eidx_q].snd;
			od_q.report_error    <= res_q[eidx_q].rep;
			od_q.clear_error     <= res_q[eidx_q].clr;
			od_q.status          <= res_q[eidx_q].status;
			od_q.all_active      <= tick_q && aa_q;
			od_q.all_operational <= tick_q && ao_q;
			od_q.last            <= (RCNT_W'(eidx_q) + RCNT_W'(1) == rcnt_q);
		end
	end

	assign rsp.valid = ov_q;
	assign rsp.data  = od_q;

endmodule

// ===== hw/rtl/node_guarding_master_monitor_top.sv =====
// ----------------------------------------------------------------------------
// Node guarding master monitor
// Guards up to NODES slave nodes: setup, guard replies and periodic ticks.
// ----------------------------------------------------------------------------
// Usage: items enter on req, a valid/ready channel; results leave on rsp.
// An item is taken on a rising clock edge with valid and ready both high.
// A setup item writes one slot if the slot is below NODES and the node id is
// not zero, and gives exactly one result. A received frame gives no result;
// it only updates the matching slot. A tick gives one result per expired
// slot (at most eight), or a single summary result when no slot expired; the
// final result of an item has last set. The front end drops frames and
// unused modes that cannot have an effect and queues the others in a
// two-entry queue, so req can stay ready while the back end works, until
// the queue is full. The back end takes an item from the queue, then walks
// the slot table one slot per cycle: a tick walks every slot and a frame
// walks until it finds the matching slot or reaches the end. Each result
// is then loaded into the output register.
// When the receiver stalls, the output register holds its result and the
// back end waits; the queue keeps taking items until it is full.
// Reset clears the whole slot table (every slot disabled), the queue and the
// output valid flag; the block takes items on the first cycle after reset.
// ----------------------------------------------------------------------------
module node_guarding_master_monitor_top #(
	parameter int NODES = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	ngm_chan_if.sink  req,
	ngm_chan_if.source rsp
);
	import ngm_pkg::*;

	cmd_req_t cmd;
	logic     cmd_ready;

	ngm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.cmd_ready (cmd_ready)
	);

	ngm_back #(.NODES(NODES)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_ready (cmd_ready),
		.rsp       (rsp)
	);

`ifndef ASSERT_OFF
	// A queued command waits until the back end takes it.
	a_cmd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && !cmd_ready |=> cmd.valid)
		else $error("queued command lost");

	// A rejected setup result (status set) is always the only result of its item.
	a_setup_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.status |-> rsp.data.last)
		else $error("setup result without last");

	// A rejected setup never sends a request nor reports an error.
	a_setup_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.status |-> !rsp.data.send_request && !rsp.data.report_error)
		else $error("setup result with tick flags");

	// Operational summary implies the active summary.
	a_summary: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.all_operational |-> rsp.data.all_active)
		else $error("operational without active");
`endif

endmodule
